// ===== design/mgis_pkg.sv =====
// ----------------------------------------------------------------------------
// mgis_pkg
// Shared types and constants for the MPEG-2 GOP index scanner.
// ----------------------------------------------------------------------------
package mgis_pkg;

  localparam int MAX_GOP_PICTURES = 32;
  localparam int IDX_W = $clog2(MAX_GOP_PICTURES);
  localparam int LEN_W = $clog2(MAX_GOP_PICTURES + 1);

  localparam int ACC_W = 24;
  localparam int MUL_W = 7;
  localparam int ADD_W = 6;

  localparam logic [7:0] SC_SEQUENCE = 8'hB3;
  localparam logic [7:0] SC_GOP      = 8'hB8;
  localparam logic [7:0] SC_PICTURE  = 8'h00;

  localparam logic [3:0] FRAME_RATE_25 = 4'd3;
  localparam logic [MUL_W-1:0] SIXTY   = 7'd60;
  localparam logic [MUL_W-1:0] FPS     = 7'd25;
  localparam logic [3:0] KEY_NONE      = 4'd10;
  localparam logic [2:0] TYPE_I        = 3'd1;

  localparam logic [2:0] ERR_FRAME_RATE = 3'd1;
  localparam logic [2:0] ERR_EMPTY_GOP  = 3'd2;

  localparam logic OP_START_CODE = 1'b0;
  localparam logic OP_END        = 1'b1;

  typedef enum logic [1:0] {
    REC_ENTRY   = 2'd0,
    REC_SYMBOL  = 2'd1,
    REC_SUMMARY = 2'd2,
    REC_ERROR   = 2'd3
  } rec_kind_t;

  // Input tdata, first field in the highest bits.
  typedef struct packed {
    logic [47:0] byte_position;
    logic [7:0]  header_b7;
    logic [7:0]  header_b6;
    logic [7:0]  header_b5;
    logic [7:0]  header_b4;
    logic [7:0]  start_code;
  } in_data_t;

  typedef struct packed {
    logic header_complete;
    logic operation;
  } in_user_t;

  // Output tdata, first field in the highest bits, padded to 176 bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [23:0] picture_size;
    logic        discontinuity;
    logic [2:0]  symbol;
    logic        closed_gop;
    logic [22:0] timecode;
    logic [3:0]  aspect_code;
    logic [3:0]  key_digit;
    logic [31:0] picture_number;
    logic [31:0] gop_number;
    logic [47:0] position;
  } out_data_t;

  // Request to the shared multiply-add unit.
  typedef struct packed {
    logic             en;
    logic [ACC_W-1:0] a;
    logic [MUL_W-1:0] mult;
    logic [ADD_W-1:0] addend;
  } mac_req_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CALC   = 6'b000100,
    S_RUN    = 6'b001000,
    S_GOPFIN = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

endpackage

// ===== design/mgis_mac.sv =====
// ----------------------------------------------------------------------------
// mgis_mac
// Shared multiply-add unit with a registered accumulator: acc = a * mult + addend.
// ----------------------------------------------------------------------------
module mgis_mac import mgis_pkg::*; (
  input  logic             clk,
  input  mac_req_t         req,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W+MUL_W-1:0] prod;

  always_comb begin
    prod    = req.a * req.mult;
    acc_nxt = prod[ACC_W-1:0] + ACC_W'(req.addend);
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/mpeg2_gop_index_scanner.sv =====
// ----------------------------------------------------------------------------
// mpeg2_gop_index_scanner
// Builds a GOP index from MPEG-2 start-code events.
// ----------------------------------------------------------------------------
// Each input request carries one start-code event (code byte, four header
// bytes, byte offset) or an end-of-stream marker in in_tuser. Results leave
// on the out_ channel; out_tuser gives the record kind and out_tlast marks
// the final record caused by one request.
// A request is taken only while the sequencer is idle. Sequence and picture
// headers are decoded and pass through the emit state when they emit an
// entry or an error record. A GOP header walks the type symbols of the GOP
// it closes (at most 32) once the timecode frame count is built in three
// passes through the single multiply-add unit; when it raises the empty-GOP
// error it goes straight to the emit state. End of stream walks the stored
// symbols (at most 32) and then emits the summary.
// Results go through a single output register: when the receiver stalls,
// the sequencer waits on that register, and a request without results can
// still be taken while the last record is held.
// After an error record or the summary, requests are taken and ignored until
// reset. Reset is synchronous and clears all counters and the type store at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mpeg2_gop_index_scanner import mgis_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // start_code, header_b4..b7, byte_position
  input  logic [1:0]   in_tuser,   // operation, header_complete
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // position, gop_number, picture_number,
                                   // key_digit, aspect_code, timecode,
                                   // closed_gop, symbol, discontinuity,
                                   // picture_size, zero pad
  output logic [1:0]   out_tuser,  // record_kind
  output logic         out_tlast
);

  state_t      state_r, state_nxt;
  in_data_t    in_data_r;
  in_user_t    in_user_r;

  logic [31:0] picture_count_r, picture_count_nxt;
  logic [31:0] gop_count_r, gop_count_nxt;
  logic [31:0] gop_first_r, gop_first_nxt;
  logic [47:0] seq_pos_r, seq_pos_nxt;
  logic [3:0]  aspect_r, aspect_nxt;
  logic [11:0] max_w_r, max_w_nxt;
  logic [11:0] max_h_r, max_h_nxt;
  logic [23:0] gop_tc_r, gop_tc_nxt;
  logic        entry_pending_r, entry_pending_nxt;
  logic [31:0] count_adjust_r, count_adjust_nxt;
  logic        halted_r, halted_nxt;
  logic        gop_disc_r, gop_disc_nxt;
  logic [2:0]  type_store_r [MAX_GOP_PICTURES];

  logic [31:0] run_cnt_r, run_cnt_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic [LEN_W-1:0] run_idx_r, run_idx_nxt;
  logic        run_to_sum_r, run_to_sum_nxt;
  rec_kind_t   emit_kind_r, emit_kind_nxt;
  logic [2:0]  err_code_r, err_code_nxt;
  logic [1:0]  step_r, step_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_data_t   out_data_r, out_data_nxt;
  rec_kind_t   out_kind_r, out_kind_nxt;
  logic        out_last_r, out_last_nxt;

  mac_req_t         mac_req;
  logic [ACC_W-1:0] mac_acc;

  logic        type_wr;
  logic        type_clr;
  logic [9:0]  tref;
  logic [2:0]  ftype;
  logic [11:0] seq_w;
  logic [11:0] seq_h;
  logic [31:0] run_count;
  logic [LEN_W-1:0] run_lim;
  logic [31:0] tc_frames;
  logic [31:0] expected;
  logic        out_free;
  logic        in_fire;
  logic        run_end;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign tref  = {in_data_r.header_b4, in_data_r.header_b5[7:6]};
  assign ftype = in_data_r.header_b5[5:3];
  assign seq_w = {in_data_r.header_b4, in_data_r.header_b5[7:4]};
  assign seq_h = {in_data_r.header_b5[3:0], in_data_r.header_b6};

  assign run_count = picture_count_r - gop_first_r;
  assign run_lim   = (run_count > 32'(MAX_GOP_PICTURES)) ?
                     LEN_W'(MAX_GOP_PICTURES) : run_count[LEN_W-1:0];
  assign run_end   = (run_idx_r == run_len_r - LEN_W'(1));

  assign tc_frames = 32'(mac_acc);
  assign expected  = picture_count_r - count_adjust_r;

  mgis_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  always_comb begin
    state_nxt         = state_r;
    picture_count_nxt = picture_count_r;
    gop_count_nxt     = gop_count_r;
    gop_first_nxt     = gop_first_r;
    seq_pos_nxt       = seq_pos_r;
    aspect_nxt        = aspect_r;
    max_w_nxt         = max_w_r;
    max_h_nxt         = max_h_r;
    gop_tc_nxt        = gop_tc_r;
    entry_pending_nxt = entry_pending_r;
    count_adjust_nxt  = count_adjust_r;
    halted_nxt        = halted_r;
    gop_disc_nxt      = gop_disc_r;
    run_cnt_nxt       = run_cnt_r;
    run_len_nxt       = run_len_r;
    run_idx_nxt       = run_idx_r;
    run_to_sum_nxt    = run_to_sum_r;
    emit_kind_nxt     = emit_kind_r;
    err_code_nxt      = err_code_r;
    step_nxt          = step_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_data_nxt      = out_data_r;
    out_kind_nxt      = out_kind_r;
    out_last_nxt      = out_last_r;
    type_wr           = 1'b0;
    type_clr          = 1'b0;
    mac_req           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt   = S_IDLE;
        run_idx_nxt = '0;
        if (!halted_r) begin
          if (in_user_r.operation == OP_END) begin
            run_cnt_nxt    = run_count;
            run_len_nxt    = run_lim;
            run_to_sum_nxt = 1'b1;
            emit_kind_nxt  = REC_SUMMARY;
            state_nxt      = (run_lim != '0) ? S_RUN : S_EMIT;
          end else begin
            unique case (in_data_r.start_code)
              SC_SEQUENCE: begin
                seq_pos_nxt = in_data_r.byte_position;
                if (in_user_r.header_complete) begin
                  if (in_data_r.header_b7[3:0] != FRAME_RATE_25) begin
                    emit_kind_nxt = REC_ERROR;
                    err_code_nxt  = ERR_FRAME_RATE;
                    state_nxt     = S_EMIT;
                  end else begin
                    aspect_nxt = in_data_r.header_b7[7:4];
                    if (seq_w > max_w_r) begin
                      max_w_nxt = seq_w;
                    end
                    if (seq_h > max_h_r) begin
                      max_h_nxt = seq_h;
                    end
                  end
                end
              end
              SC_GOP: begin
                if (entry_pending_r) begin
                  emit_kind_nxt = REC_ERROR;
                  err_code_nxt  = ERR_EMPTY_GOP;
                  state_nxt     = S_EMIT;
                end else if (in_user_r.header_complete) begin
                  // closed flag, hour, minute, second, frame
                  gop_tc_nxt = {in_data_r.header_b7[6],
                                in_data_r.header_b4[6:2],
                                in_data_r.header_b4[1:0], in_data_r.header_b5[7:4],
                                in_data_r.header_b5[2:0], in_data_r.header_b6[7:5],
                                in_data_r.header_b6[4:0], in_data_r.header_b7[7]};
                  run_cnt_nxt    = run_count;
                  run_len_nxt    = (picture_count_r != '0) ? run_lim : '0;
                  run_to_sum_nxt = 1'b0;
                  step_nxt       = '0;
                  state_nxt      = S_CALC;
                end
              end
              SC_PICTURE: begin
                if (in_user_r.header_complete) begin
                  type_wr = (tref < 10'(MAX_GOP_PICTURES));
                  if (entry_pending_r) begin
                    emit_kind_nxt = REC_ENTRY;
                    state_nxt     = S_EMIT;
                  end else begin
                    picture_count_nxt = picture_count_r + 32'd1;
                  end
                end else begin
                  picture_count_nxt = picture_count_r + 32'd1;
                end
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end

      // Timecode to a 25 fps frame count in three multiply-add passes.
      S_CALC: begin
        mac_req.en = 1'b1;
        unique case (step_r)
          2'd0: begin
            mac_req.a      = ACC_W'(gop_tc_r[22:18]);
            mac_req.mult   = SIXTY;
            mac_req.addend = gop_tc_r[17:12];
          end
          2'd1: begin
            mac_req.a      = mac_acc;
            mac_req.mult   = SIXTY;
            mac_req.addend = gop_tc_r[11:6];
          end
          default: begin
            mac_req.a      = mac_acc;
            mac_req.mult   = FPS;
            mac_req.addend = gop_tc_r[5:0];
          end
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = (run_len_r != '0) ? S_RUN : S_GOPFIN;
        end
      end

      S_RUN: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_kind_nxt                = REC_SYMBOL;
          out_data_nxt                = '0;
          out_data_nxt.gop_number     = gop_count_r;
          out_data_nxt.picture_number = run_cnt_r;
          out_data_nxt.symbol         = type_store_r[run_idx_r[IDX_W-1:0]];
          out_last_nxt                = run_end && !run_to_sum_r;
          run_idx_nxt                 = run_idx_r + LEN_W'(1);
          if (run_end) begin
            state_nxt = run_to_sum_r ? S_EMIT : S_GOPFIN;
          end
        end
      end

      S_GOPFIN: begin
        gop_disc_nxt = (tc_frames != expected);
        if (tc_frames != expected) begin
          count_adjust_nxt = picture_count_r - tc_frames;
        end
        type_clr          = (picture_count_r != '0);
        entry_pending_nxt = 1'b1;
        gop_count_nxt     = gop_count_r + 32'd1;
        state_nxt         = S_IDLE;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = emit_kind_r;
          out_last_nxt  = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          unique case (emit_kind_r)
            REC_ENTRY: begin
              out_data_nxt.position       = seq_pos_r;
              out_data_nxt.gop_number     = gop_count_r;
              out_data_nxt.picture_number = picture_count_r;
              out_data_nxt.key_digit      = (ftype == TYPE_I && tref < 10'd10) ?
                                            tref[3:0] : KEY_NONE;
              out_data_nxt.aspect_code    = aspect_r;
              out_data_nxt.timecode       = gop_tc_r[22:0];
              out_data_nxt.closed_gop     = gop_tc_r[23];
              out_data_nxt.discontinuity  = gop_disc_r;
              gop_first_nxt     = picture_count_r;
              entry_pending_nxt = 1'b0;
              picture_count_nxt = picture_count_r + 32'd1;
            end
            REC_SUMMARY: begin
              out_data_nxt.position       = in_data_r.byte_position;
              out_data_nxt.gop_number     = gop_count_r + 32'd1;
              out_data_nxt.picture_number = picture_count_r;
              out_data_nxt.aspect_code    = aspect_r;
              out_data_nxt.picture_size   = {max_w_r, max_h_r};
              halted_nxt = 1'b1;
            end
            REC_ERROR: begin
              out_data_nxt.position = in_data_r.byte_position;
              out_data_nxt.symbol   = err_code_r;
              halted_nxt = 1'b1;
            end
            default: begin
              halted_nxt = halted_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      picture_count_r <= '0;
      gop_count_r     <= '1;
      gop_first_r     <= '0;
      seq_pos_r       <= '0;
      aspect_r        <= '0;
      max_w_r         <= '0;
      max_h_r         <= '0;
      gop_tc_r        <= '0;
      entry_pending_r <= 1'b0;
      count_adjust_r  <= '0;
      halted_r        <= 1'b0;
      gop_disc_r      <= 1'b0;
      run_cnt_r       <= '0;
      run_len_r       <= '0;
      run_idx_r       <= '0;
      run_to_sum_r    <= 1'b0;
      emit_kind_r     <= REC_ENTRY;
      err_code_r      <= '0;
      step_r          <= '0;
      out_valid_r     <= 1'b0;
      out_kind_r      <= REC_ENTRY;
      out_last_r      <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      picture_count_r <= picture_count_nxt;
      gop_count_r     <= gop_count_nxt;
      gop_first_r     <= gop_first_nxt;
      seq_pos_r       <= seq_pos_nxt;
      aspect_r        <= aspect_nxt;
      max_w_r         <= max_w_nxt;
      max_h_r         <= max_h_nxt;
      gop_tc_r        <= gop_tc_nxt;
      entry_pending_r <= entry_pending_nxt;
      count_adjust_r  <= count_adjust_nxt;
      halted_r        <= halted_nxt;
      gop_disc_r      <= gop_disc_nxt;
      run_cnt_r       <= run_cnt_nxt;
      run_len_r       <= run_len_nxt;
      run_idx_r       <= run_idx_nxt;
      run_to_sum_r    <= run_to_sum_nxt;
      emit_kind_r     <= emit_kind_nxt;
      err_code_r      <= err_code_nxt;
      step_r          <= step_nxt;
      out_valid_r     <= out_valid_nxt;
      out_kind_r      <= out_kind_nxt;
      out_last_r      <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      in_data_r <= in_data_t'(in_tdata);
      in_user_r <= in_user_t'(in_tuser);
    end
  end

  // The type store has a defined reset value and is wiped when a GOP closes.
  always_ff @(posedge clk) begin
    if (!rst_n || type_clr) begin
      for (int i = 0; i < MAX_GOP_PICTURES; i++) begin
        type_store_r[i] <= '0;
      end
    end else if (type_wr) begin
      type_store_r[tref[IDX_W-1:0]] <= ftype;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/mgis_checker.sv =====
// ----------------------------------------------------------------------------
// mgis_checker
// Port-level checks for the GOP index scanner, bound to the top level.
// ----------------------------------------------------------------------------
module mgis_checker import mgis_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  out_data_t od;
  assign od = out_data_t'(out_tdata);

  // A stalled record must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("output record changed while stalled");

  // Taking a request makes the sequencer busy, so requests are never taken back to back.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken in back-to-back cycles");

  // Entry, summary and error records always close the results of a request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != REC_SYMBOL |-> out_tlast)
    else $error("non-symbol record without last");

  // Error records carry a known error code and no counters.
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REC_ERROR |->
    (od.symbol == ERR_FRAME_RATE || od.symbol == ERR_EMPTY_GOP) &&
    od.gop_number == '0 && od.picture_number == '0)
    else $error("malformed error record");

endmodule

bind mpeg2_gop_index_scanner mgis_checker u_mgis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the MPEG-2 GOP index scanner.
// ----------------------------------------------------------------------------
// A generator builds one start-code stream: a short directed opening, then
// random GOPs with random picture types, a few long GOPs, timecode jumps,
// incomplete headers and ignored codes. The stream closes with an end
// marker, a bad frame rate or an empty GOP, followed by requests that the
// halted block must ignore. Every accepted request is run through a local
// model of the index logic; each record on the out_ side is checked field by
// field against the oldest predicted record. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
  import mgis_pkg::*;

  localparam int LIMIT       = 4000;
  localparam int TAIL        = 80;
  localparam int DRAIN_PAUSE = 48;

  typedef struct packed {
    logic     hold;
    in_user_t u;
    in_data_t d;
  } scan_event_t;

  typedef struct packed {
    rec_kind_t kind;
    logic      last;
    out_data_t data;
  } index_rec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;   // start_code, header_b4..b7, byte_position
  logic [1:0]   in_tuser = '0;   // operation, header_complete
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;       // position, gop_number, picture_number, key_digit,
                                 // aspect_code, timecode, closed_gop, symbol,
                                 // discontinuity, picture_size, zero pad
  logic [1:0]   out_tuser;       // record_kind
  logic         out_tlast;

  mpeg2_gop_index_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  scan_event_t events_q[$];
  index_rec_t  records_due[$];
  index_rec_t  staged_recs[$];

  int          fails = 0;
  int          idle_cycles = 0;
  logic [31:0] cyc = '0;

  // Model of the index logic.
  logic [31:0] pic_cnt = '0;
  logic [31:0] gop_idx = '1;
  logic [31:0] gop_first = '0;
  logic [47:0] seq_pos = '0;
  logic [3:0]  aspect = '0;
  logic [11:0] max_w = '0;
  logic [11:0] max_h = '0;
  logic [23:0] gop_tc = '0;
  logic        entry_wait = 1'b0;
  logic [31:0] cnt_adj = '0;
  logic [2:0]  type_mem [MAX_GOP_PICTURES];
  logic        stopped = 1'b0;
  logic        gop_disc = 1'b0;

  // Generator's view of the stream, used to keep sequences well formed.
  logic [31:0] gen_pics = '0;
  logic [31:0] gen_adj = '0;
  logic        gen_pending = 1'b0;
  logic        hold_next = 1'b0;

  function automatic logic [31:0] tc_frames(input logic [31:0] hr, mn, sc, fr);
    return ((hr * 60 + mn) * 60 + sc) * 25 + fr;
  endfunction

  task automatic stage_run();
    logic [31:0] cnt;
    int          lim;
    index_rec_t  r;
    cnt = pic_cnt - gop_first;
    lim = (cnt > MAX_GOP_PICTURES) ? MAX_GOP_PICTURES : int'(cnt);
    for (int k = 0; k < lim; k++) begin
      r = '0;
      r.kind = REC_SYMBOL;
      r.data.gop_number = gop_idx;
      r.data.picture_number = cnt;
      r.data.symbol = type_mem[k];
      staged_recs.push_back(r);
    end
  endtask

  task automatic stage_error(input logic [47:0] pos, input logic [2:0] code);
    index_rec_t r;
    r = '0;
    r.kind = REC_ERROR;
    r.data.position = pos;
    r.data.symbol = code;
    staged_recs.push_back(r);
    stopped = 1'b1;
  endtask

  task automatic derive_records(input in_data_t d, input in_user_t u);
    index_rec_t  r;
    logic [11:0] w, h;
    logic [31:0] hr, mn, sc, fr, t;
    logic [9:0]  tref;
    logic [2:0]  ft;
    int          n;
    if (stopped) return;
    if (u.operation == OP_END) begin
      stage_run();
      r = '0;
      r.kind = REC_SUMMARY;
      r.data.position = d.byte_position;
      r.data.gop_number = gop_idx + 32'd1;
      r.data.picture_number = pic_cnt;
      r.data.aspect_code = aspect;
      r.data.picture_size = {max_w, max_h};
      staged_recs.push_back(r);
      stopped = 1'b1;
    end else if (d.start_code == SC_SEQUENCE) begin
      seq_pos = d.byte_position;
      if (u.header_complete) begin
        w = {d.header_b4, d.header_b5[7:4]};
        h = {d.header_b5[3:0], d.header_b6};
        if (d.header_b7[3:0] != FRAME_RATE_25) begin
          stage_error(d.byte_position, ERR_FRAME_RATE);
        end else begin
          aspect = d.header_b7[7:4];
          if (w > max_w) max_w = w;
          if (h > max_h) max_h = h;
        end
      end
    end else if (d.start_code == SC_GOP) begin
      if (entry_wait) begin
        stage_error(d.byte_position, ERR_EMPTY_GOP);
      end else if (u.header_complete) begin
        hr = 32'(d.header_b4[6:2]);
        mn = 32'({d.header_b4[1:0], d.header_b5[7:4]});
        sc = 32'({d.header_b5[2:0], d.header_b6[7:5]});
        fr = 32'({d.header_b6[4:0], d.header_b7[7]});
        t = tc_frames(hr, mn, sc, fr);
        gop_tc = {d.header_b7[6], hr[4:0], mn[5:0], sc[5:0], fr[5:0]};
        if (pic_cnt != 0) begin
          stage_run();
          for (int k = 0; k < MAX_GOP_PICTURES; k++) type_mem[k] = '0;
        end
        gop_disc = (t != pic_cnt - cnt_adj);
        if (gop_disc) cnt_adj = pic_cnt - t;
        entry_wait = 1'b1;
        gop_idx = gop_idx + 32'd1;
      end
    end else if (d.start_code == SC_PICTURE) begin
      if (u.header_complete) begin
        tref = {d.header_b4, d.header_b5[7:6]};
        ft = d.header_b5[5:3];
        if (tref < MAX_GOP_PICTURES) type_mem[tref[IDX_W-1:0]] = ft;
        if (entry_wait) begin
          gop_first = pic_cnt;
          r = '0;
          r.kind = REC_ENTRY;
          r.data.position = seq_pos;
          r.data.gop_number = gop_idx;
          r.data.picture_number = gop_first;
          r.data.key_digit = (ft == TYPE_I && tref < 10) ? tref[3:0] : KEY_NONE;
          r.data.aspect_code = aspect;
          r.data.timecode = gop_tc[22:0];
          r.data.closed_gop = gop_tc[23];
          r.data.discontinuity = gop_disc;
          staged_recs.push_back(r);
        end
        entry_wait = 1'b0;
      end
      pic_cnt = pic_cnt + 32'd1;
    end
    n = staged_recs.size();
    for (int i = 0; i < n; i++) begin
      r = staged_recs[i];
      r.last = (i == n - 1);
      records_due.push_back(r);
    end
    staged_recs.delete();
  endtask

  // ---- stimulus builders ----

  task automatic add_item(input logic [7:0] code, b4, b5, b6, b7, input logic op, full);
    scan_event_t ev;
    int          r;
    r = $urandom_range(0, 19);
    ev.hold = hold_next;
    ev.u.operation = op;
    ev.u.header_complete = full;
    ev.d.start_code = code;
    ev.d.header_b4 = b4;
    ev.d.header_b5 = b5;
    ev.d.header_b6 = b6;
    ev.d.header_b7 = b7;
    if (r == 0) ev.d.byte_position = '0;
    else if (r == 1) ev.d.byte_position = '1;
    else ev.d.byte_position = {16'($urandom), 32'($urandom)};
    events_q.push_back(ev);
    hold_next = 1'b0;
  endtask

  task automatic add_seq(input logic [11:0] w, h, input logic [3:0] asp, rate,
                         input logic full);
    add_item(SC_SEQUENCE, w[11:4], {w[3:0], h[11:8]}, h[7:0], {asp, rate},
             OP_START_CODE, full);
  endtask

  task automatic add_gop(input logic [4:0] hr, input logic [5:0] mn, sc, fr,
                         input logic cl, full);
    logic [31:0] t;
    add_item(SC_GOP, {1'($urandom), hr, mn[5:4]}, {mn[3:0], 1'($urandom), sc[5:3]},
             {sc[2:0], fr[5:1]}, {fr[0], cl, 6'($urandom)}, OP_START_CODE, full);
    if (full) begin
      t = tc_frames(32'(hr), 32'(mn), 32'(sc), 32'(fr));
      if (t != gen_pics - gen_adj) gen_adj = gen_pics - t;
      gen_pending = 1'b1;
    end
  endtask

  // GOP header whose timecode agrees with the 25 fps picture count.
  task automatic add_gop_tc(input logic cl);
    logic [31:0] t;
    t = gen_pics - gen_adj;
    add_gop(5'((t / 90000) % 32), 6'((t / 1500) % 60), 6'((t / 25) % 60), 6'(t % 25),
            cl, 1'b1);
  endtask

  task automatic add_pic(input logic [9:0] tref, input logic [2:0] ft, input logic full);
    add_item(SC_PICTURE, tref[9:2], {tref[1:0], ft, 3'($urandom)}, 8'($urandom),
             8'($urandom), OP_START_CODE, full);
    if (full) gen_pending = 1'b0;
    gen_pics = gen_pics + 32'd1;
  endtask

  task automatic add_other();
    logic [7:0] code;
    code = 8'($urandom);
    while (code == SC_SEQUENCE || code == SC_GOP || code == SC_PICTURE) code = 8'($urandom);
    add_item(code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), OP_START_CODE,
             1'($urandom));
  endtask

  task automatic add_end();
    add_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), OP_END,
             1'($urandom));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cyc[9:7] == 3'd0) return 0;
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fails++;
    end
  endtask

  // ---- driver ----

  scan_event_t cur_ev = '0;
  scan_event_t head_ev;
  logic        in_taken = 1'b0;
  logic        drained = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (events_q.size() != 0) head_ev = events_q[0];
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (events_q.size() != 0 && head_ev.hold && !drained) begin
        // Hold the sender back until the block has delivered everything.
        in_tvalid <= 1'b0;
        if (records_due.size() == 0) begin
          drained = 1'b1;
          in_gap = DRAIN_PAUSE;
        end
      end else if (events_q.size() != 0) begin
        cur_ev = events_q.pop_front();
        drained = 1'b0;
        in_tdata <= cur_ev.d;
        in_tuser <= cur_ev.u;
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // ---- monitor ----

  index_rec_t want_rec;
  out_data_t  got_data;

  always @(posedge clk) begin
    cyc = cyc + 32'd1;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got_data = out_tdata;
      if (records_due.size() == 0) begin
        $error("record with no request behind it, kind %0d", out_tuser);
        fails++;
      end else begin
        want_rec = records_due.pop_front();
        check_field("record_kind", 64'(want_rec.kind), 64'(out_tuser));
        check_field("last", 64'(want_rec.last), 64'(out_tlast));
        check_field("position", 64'(want_rec.data.position), 64'(got_data.position));
        check_field("gop_number", 64'(want_rec.data.gop_number), 64'(got_data.gop_number));
        check_field("picture_number", 64'(want_rec.data.picture_number),
                    64'(got_data.picture_number));
        check_field("key_digit", 64'(want_rec.data.key_digit), 64'(got_data.key_digit));
        check_field("aspect_code", 64'(want_rec.data.aspect_code),
                    64'(got_data.aspect_code));
        check_field("timecode", 64'(want_rec.data.timecode), 64'(got_data.timecode));
        check_field("closed_gop", 64'(want_rec.data.closed_gop), 64'(got_data.closed_gop));
        check_field("symbol", 64'(want_rec.data.symbol), 64'(got_data.symbol));
        check_field("discontinuity", 64'(want_rec.data.discontinuity),
                    64'(got_data.discontinuity));
        check_field("picture_size", 64'(want_rec.data.picture_size),
                    64'(got_data.picture_size));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      derive_records(cur_ev.d, cur_ev.u);
      in_taken = 1'b1;
    end
  end

  initial begin
    while (idle_cycles < LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---- stimulus and end of run ----

  initial begin
    int   npics;
    int   sel;
    logic [3:0] bad_rate;
    for (int k = 0; k < MAX_GOP_PICTURES; k++) type_mem[k] = '0;

    // Directed opening. A picture ahead of the first GOP gives a run
    // that belongs to GOP index all-ones.
    add_pic(10'd0, TYPE_I, 1'b1);
    add_seq(12'hFFF, 12'hFFF, 4'hF, 4'hA, 1'b0);
    add_seq(12'hFFF, 12'hFFF, 4'hF, FRAME_RATE_25, 1'b1);
    add_seq(12'h000, 12'h000, 4'h0, FRAME_RATE_25, 1'b1);
    add_other();
    add_gop(5'd31, 6'd63, 6'd63, 6'd63, 1'b1, 1'b0);
    add_gop_tc(1'b1);
    // An incomplete picture header counts but leaves the entry pending.
    add_pic(10'h3FF, 3'd7, 1'b0);
    add_pic(10'd0, TYPE_I, 1'b1);
    add_pic(10'd9, 3'd2, 1'b1);
    add_pic(10'h3FF, 3'd7, 1'b1);
    add_pic(10'd31, 3'd3, 1'b1);
    add_pic(10'd32, 3'd4, 1'b1);
    add_pic(10'd5, 3'd4, 1'b1);
    add_pic(10'd6, 3'd5, 1'b1);
    add_pic(10'd7, 3'd6, 1'b1);
    add_pic(10'd8, 3'd0, 1'b1);
    hold_next = 1'b1;
    add_gop(5'd31, 6'd63, 6'd63, 6'd63, 1'b0, 1'b1);
    add_pic(10'd9, TYPE_I, 1'b1);
    add_gop_tc(1'b0);
    add_pic(10'd10, TYPE_I, 1'b1);
    add_gop_tc(1'b1);
    add_pic(10'd3, 3'd2, 1'b1);

    // Random GOPs; the first picture of each is complete so that the next
    // GOP header never finds an entry still pending.
    while (events_q.size() < 340) begin
      if ($urandom_range(0, 5) == 0)
        add_seq(12'($urandom), 12'($urandom), 4'($urandom), FRAME_RATE_25, 1'b1);
      if ($urandom_range(0, 9) == 0)
        add_seq(12'($urandom), 12'($urandom), 4'($urandom), 4'($urandom), 1'b0);
      if ($urandom_range(0, 7) == 0)
        add_gop(5'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), 1'b0);
      if ($urandom_range(0, 6) == 0)
        add_gop(5'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), 1'b1);
      else
        add_gop_tc(1'($urandom));
      npics = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      for (int k = 0; k < npics; k++) begin
        sel = $urandom_range(0, 19);
        if (k == 0)
          add_pic(10'($urandom_range(0, 12)),
                  ($urandom_range(0, 9) < 7) ? TYPE_I : 3'($urandom), 1'b1);
        else if (sel < 2)
          add_pic(10'($urandom), 3'($urandom), 1'b0);
        else if (sel == 2)
          add_other();
        else
          add_pic(($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, npics)),
                  3'($urandom), 1'b1);
      end
      if ($urandom_range(0, 4) == 0) hold_next = 1'b1;
    end

    case ($urandom_range(0, 2))
      0: begin
        if ($urandom_range(0, 1) == 0) add_gop_tc(1'($urandom));
        add_end();
      end
      1: begin
        bad_rate = 4'($urandom_range(0, 14));
        if (bad_rate >= FRAME_RATE_25) bad_rate = bad_rate + 4'd1;
        add_seq(12'($urandom), 12'($urandom), 4'($urandom), bad_rate, 1'b1);
      end
      default: begin
        add_gop_tc(1'($urandom));
        add_gop(5'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 1'($urandom),
                1'($urandom));
      end
    endcase
    // The block has stopped; these must produce nothing.
    add_pic(10'd0, TYPE_I, 1'b1);
    add_gop_tc(1'b0);
    add_other();
    add_end();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (events_q.size() != 0 || in_tvalid) @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (records_due.size() != 0) begin
      $error("%0d predicted records never arrived", records_due.size());
      fails++;
    end
    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
